@@ rtl/ffa_pkg.sv @@
// Shared types, codes and microcode ROM for the first-fit free-list allocator.
// Used by ffa_seq, ffa_slot_store and first_fit_free_list_allocator_core.
package ffa_pkg;

    localparam int LEN_W    = 8;
    localparam int ADDR_W   = 7;
    localparam int STATUS_W = 3;
    localparam int STEP_W   = 3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_FROM_LIST = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FROM_POOL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd5;

    // Program step addresses
    localparam logic [STEP_W-1:0] STEP_WAIT     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SCAN     = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DRAIN    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd3;
    localparam logic [STEP_W-1:0] STEP_ALLOC    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_FREE     = 3'd5;

    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_IN_VALID,
        JC_SCAN_LAST,
        JC_CMD_FREE,
        JC_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic              accept;
        logic              scan;
        logic              commit_alloc;
        logic              commit_free;
        cond_t             cond;
        logic [STEP_W-1:0] on_true;
        logic [STEP_W-1:0] on_false;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic scan_last;
        logic cmd_free;
        logic out_free;
    } flags_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{accept: 1'b0, scan: 1'b0, commit_alloc: 1'b0, commit_free: 1'b0,
              cond: JC_ALWAYS, on_true: STEP_WAIT, on_false: STEP_WAIT};
        case (step)
            STEP_WAIT: begin
                w.accept   = 1'b1;
                w.cond     = JC_IN_VALID;
                w.on_true  = STEP_SCAN;
                w.on_false = STEP_WAIT;
            end
            STEP_SCAN: begin
                w.scan     = 1'b1;
                w.cond     = JC_SCAN_LAST;
                w.on_true  = STEP_DRAIN;
                w.on_false = STEP_SCAN;
            end
            STEP_DRAIN: begin
                w.cond     = JC_ALWAYS;
                w.on_true  = STEP_DISPATCH;
                w.on_false = STEP_DISPATCH;
            end
            STEP_DISPATCH: begin
                w.cond     = JC_CMD_FREE;
                w.on_true  = STEP_FREE;
                w.on_false = STEP_ALLOC;
            end
            STEP_ALLOC: begin
                w.commit_alloc = 1'b1;
                w.cond         = JC_OUT_FREE;
                w.on_true      = STEP_WAIT;
                w.on_false     = STEP_ALLOC;
            end
            STEP_FREE: begin
                w.commit_free = 1'b1;
                w.cond        = JC_OUT_FREE;
                w.on_true     = STEP_WAIT;
                w.on_false    = STEP_FREE;
            end
            default: begin
                w.cond     = JC_ALWAYS;
                w.on_true  = STEP_WAIT;
                w.on_false = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/ffa_seq.sv @@
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on ffa_pkg.
module ffa_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffa_pkg::flags_t   flags,
    output ffa_pkg::ctrl_t    ctrl
);

    logic [ffa_pkg::STEP_W-1:0] step_reg;
    logic [ffa_pkg::STEP_W-1:0] step_next;
    logic                       taken;

    always_comb begin
        ctrl = ffa_pkg::ucode(step_reg);
        case (ctrl.cond)
            ffa_pkg::JC_ALWAYS:    taken = 1'b1;
            ffa_pkg::JC_IN_VALID:  taken = flags.in_valid;
            ffa_pkg::JC_SCAN_LAST: taken = flags.scan_last;
            ffa_pkg::JC_CMD_FREE:  taken = flags.cmd_free;
            ffa_pkg::JC_OUT_FREE:  taken = flags.out_free;
            default:               taken = 1'b1;
        endcase
        step_next = taken ? ctrl.on_true : ctrl.on_false;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ffa_pkg::STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ rtl/ffa_slot_store.sv @@
// Free-list slot store: valid flops plus a start/length memory with registered read.
// Depends on ffa_pkg.
module ffa_slot_store #(
    parameter int FREE_SLOTS = 16,
    parameter int IDX_W      = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [IDX_W-1:0]           rd_idx,
    output logic                       rd_valid,
    output logic [ffa_pkg::ADDR_W-1:0] rd_start,
    output logic [ffa_pkg::LEN_W-1:0]  rd_length,
    input  logic                       wr_en,
    input  logic [IDX_W-1:0]           wr_idx,
    input  logic [ffa_pkg::ADDR_W-1:0] wr_start,
    input  logic [ffa_pkg::LEN_W-1:0]  wr_length,
    input  logic                       clr_en,
    input  logic [IDX_W-1:0]           clr_idx
);

    localparam int ENTRY_W = ffa_pkg::ADDR_W + ffa_pkg::LEN_W;

    logic [FREE_SLOTS-1:0] valid_reg;
    logic [ENTRY_W-1:0]    mem [FREE_SLOTS];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (clr_en) begin
                valid_reg[clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= {wr_start, wr_length};
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_idx];
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    assign rd_valid  = rd_valid_reg;
    assign rd_start  = rd_data_reg[ENTRY_W-1:ffa_pkg::LEN_W];
    assign rd_length = rd_data_reg[ffa_pkg::LEN_W-1:0];

endmodule

@@ rtl/first_fit_free_list_allocator_core.sv @@
// First-fit free-list allocator. An item is taken in the wait step; the scan then reads
// one slot per cycle through the slot memory read port, followed by the drain, dispatch
// and commit steps. No new item is taken before the commit, which waits for a free output.
// A finished result sits in an output register while the next item is taken and scanned.
// Reset (aresetn low, synchronous) empties the free list, zeroes the pool pointer and
// drops any pending result; slot contents are not cleared.
module first_fit_free_list_allocator_core #(
    parameter int POOL_WORDS = 128,
    parameter int FREE_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] length, [14:8] address, [15] zero
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [6:0] address_res, [9:7] status, [15:10] zero
);

    localparam int LEN_W  = ffa_pkg::LEN_W;
    localparam int ADDR_W = ffa_pkg::ADDR_W;
    localparam int IDX_W  = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int BUMP_W = $clog2(POOL_WORDS);
    localparam int SUM_W  = ((BUMP_W > LEN_W) ? BUMP_W : LEN_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FREE_SLOTS - 1);

    ffa_pkg::ctrl_t  ctrl;
    ffa_pkg::flags_t flags;

    logic                 cmd_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [ADDR_W-1:0]    addr_reg;

    logic [IDX_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic                 eval_en_reg;

    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [ADDR_W-1:0]    best_start_reg, best_start_next;
    logic                 dup_reg, dup_next;
    logic                 empty_reg, empty_next;
    logic [IDX_W-1:0]     empty_idx_reg, empty_idx_next;

    logic [BUMP_W-1:0]    bump_reg;
    logic [SUM_W-1:0]     bump_sum;
    logic                 pool_fits;
    logic [ADDR_W+BUMP_W-1:0] bump_ext;

    logic                 out_valid_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic [ffa_pkg::STATUS_W-1:0] out_status_reg;
    logic                 out_free;
    logic                 in_xfer;
    logic                 do_alloc;
    logic                 do_free;

    logic                 rd_valid;
    logic [ADDR_W-1:0]    rd_start;
    logic [LEN_W-1:0]     rd_length;

    ffa_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    ffa_slot_store #(
        .FREE_SLOTS (FREE_SLOTS),
        .IDX_W      (IDX_W)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (ctrl.scan),
        .rd_idx    (scan_idx_reg),
        .rd_valid  (rd_valid),
        .rd_start  (rd_start),
        .rd_length (rd_length),
        .wr_en     (do_free && !dup_reg && empty_reg),
        .wr_idx    (empty_idx_reg),
        .wr_start  (addr_reg),
        .wr_length (len_reg),
        .clr_en    (do_alloc && found_reg),
        .clr_idx   (best_idx_reg)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && ctrl.accept;
    assign do_alloc = ctrl.commit_alloc && out_free;
    assign do_free  = ctrl.commit_free && out_free;

    assign flags.in_valid  = s_tvalid;
    assign flags.scan_last = (scan_idx_reg == LAST_IDX);
    assign flags.cmd_free  = (cmd_reg == ffa_pkg::CMD_FREE);
    assign flags.out_free  = out_free;

    assign s_tready = ctrl.accept;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_addr_reg};

    assign bump_sum  = SUM_W'(bump_reg) + SUM_W'(len_reg);
    assign pool_fits = (bump_sum < SUM_W'(POOL_WORDS));
    assign bump_ext  = {{ADDR_W{1'b0}}, bump_reg};

    // Fold one slot per cycle into the running first-fit / duplicate / free-slot search.
    always_comb begin
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_start_next = best_start_reg;
        dup_next        = dup_reg;
        empty_next      = empty_reg;
        empty_idx_next  = empty_idx_reg;
        if (eval_en_reg) begin
            if (rd_valid && rd_length >= len_reg
                && (!found_reg || rd_start < best_start_reg)) begin
                found_next      = 1'b1;
                best_idx_next   = eval_idx_reg;
                best_start_next = rd_start;
            end
            if (rd_valid && rd_start == addr_reg) begin
                dup_next = 1'b1;
            end
            if (!rd_valid && !empty_reg) begin
                empty_next     = 1'b1;
                empty_idx_next = eval_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg  <= '0;
            eval_en_reg   <= 1'b0;
            found_reg     <= 1'b0;
            dup_reg       <= 1'b0;
            empty_reg     <= 1'b0;
            bump_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            eval_en_reg <= ctrl.scan;
            if (in_xfer) begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
                dup_reg      <= 1'b0;
                empty_reg    <= 1'b0;
            end else begin
                if (ctrl.scan && scan_idx_reg != LAST_IDX) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                found_reg <= found_next;
                dup_reg   <= dup_next;
                empty_reg <= empty_next;
            end
            if (do_alloc && !found_reg && pool_fits) begin
                bump_reg <= BUMP_W'(bump_sum);
            end
            if (do_alloc || do_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg  <= s_tuser[0];
            len_reg  <= s_tdata[LEN_W-1:0];
            addr_reg <= s_tdata[LEN_W+ADDR_W-1:LEN_W];
        end
        eval_idx_reg   <= scan_idx_reg;
        best_idx_reg   <= best_idx_next;
        best_start_reg <= best_start_next;
        empty_idx_reg  <= empty_idx_next;
        if (do_alloc) begin
            if (found_reg) begin
                out_addr_reg   <= best_start_reg;
                out_status_reg <= ffa_pkg::ST_FROM_LIST;
            end else if (pool_fits) begin
                out_addr_reg   <= bump_ext[ADDR_W-1:0];
                out_status_reg <= ffa_pkg::ST_FROM_POOL;
            end else begin
                out_addr_reg   <= '0;
                out_status_reg <= ffa_pkg::ST_NO_SPACE;
            end
        end else if (do_free) begin
            out_addr_reg <= '0;
            if (dup_reg) begin
                out_status_reg <= ffa_pkg::ST_DUP;
            end else if (!empty_reg) begin
                out_status_reg <= ffa_pkg::ST_FULL;
            end else begin
                out_status_reg <= ffa_pkg::ST_FREED;
            end
        end
    end

endmodule
